// ----- rtl/core/bbpbtb_pkg.sv -----
// Shared constants for the bimodal branch predictor with target buffer.
package bbpbtb_pkg;

   localparam int COUNTER_ENTRIES_DEF = 1024;
   localparam int TARGET_ENTRIES_DEF  = 1024;

   localparam int PC_W   = 32;
   localparam int WORD_W = 30;

   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   localparam logic [1:0] CTR_MIN       = 2'd0;
   localparam logic [1:0] CTR_RESET     = 2'd1;
   localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
   localparam logic [1:0] CTR_MAX       = 2'd3;

   localparam logic [PC_W-1:0] PC_STEP = 32'd4;

endpackage

// ----- rtl/core/bbpbtb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bbpbtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bimodal_branch_predictor_btb_unit.sv -----
// Top level of the bimodal branch predictor with a direct-mapped target buffer.
// An accepted request passes through the three index stages (reciprocal multiply,
// remainder, correction), the table read and the result stage. A new request is stalled
// until the previous one returns to idle; a stalled response holds the result stage.
// Reset: a clearing pass over max(COUNTER_ENTRIES, TARGET_ENTRIES) addresses (1024 by
// default) writes both tables while requests are stalled.
module bimodal_branch_predictor_btb_unit
   import bbpbtb_pkg::*;
#(
   parameter int COUNTER_ENTRIES = COUNTER_ENTRIES_DEF,
   parameter int TARGET_ENTRIES  = TARGET_ENTRIES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_action,
   input  logic [PC_W-1:0] req_pc,
   input  logic            req_outcome_taken,
   input  logic [PC_W-1:0] req_outcome_target,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_branch_taken,
   output logic [PC_W-1:0] rsp_branch_target
);

   localparam int CIW  = $clog2(COUNTER_ENTRIES);
   localparam int TIW  = $clog2(TARGET_ENTRIES);
   localparam int TAGW = $clog2(64'd1073741823 / TARGET_ENTRIES + 64'd1);
   localparam int TW   = 1 + TAGW + PC_W;
   localparam int MAXN = (COUNTER_ENTRIES > TARGET_ENTRIES) ? COUNTER_ENTRIES
                                                            : TARGET_ENTRIES;
   localparam int CLRW = $clog2(MAXN);

   localparam logic [31:0]  MUL_C = 32'((64'd1 << 32) / COUNTER_ENTRIES);
   localparam logic [31:0]  MUL_T = 32'((64'd1 << 32) / TARGET_ENTRIES);
   localparam logic [CIW:0] NC_W  = (CIW+1)'(COUNTER_ENTRIES);
   localparam logic [TIW:0] NT_W  = (TIW+1)'(TARGET_ENTRIES);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_REM   = 7'b0001000,
      ST_FIX   = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_DATA  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CLRW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic              act_ff, act_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              taken_ff, taken_in;
   logic [PC_W-1:0]   target_ff, target_in;
   logic [WORD_W-1:0] qc_ff, qc_in;
   logic [WORD_W-1:0] qt_ff, qt_in;
   logic [CIW:0]      rc_ff, rc_in;
   logic [TIW:0]      rt_ff, rt_in;
   logic [CIW-1:0]    cidx_ff, cidx_in;
   logic [TIW-1:0]    tidx_ff, tidx_in;
   logic [TAGW-1:0]   tag_ff, tag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_taken_ff, rsp_taken_in;
   logic [PC_W-1:0]   rsp_target_ff, rsp_target_in;

   logic                     accept;
   logic                     clearing;
   logic                     rsp_load;
   logic [WORD_W-1:0]        word;
   logic [WORD_W+31:0]       prod_c;
   logic [WORD_W+31:0]       prod_t;
   logic [WORD_W+CIW:0]      qn_c;
   logic [WORD_W+TIW:0]      qn_t;
   logic [WORD_W-1:0]        diff_c;
   logic [WORD_W-1:0]        diff_t;
   logic                     c_ge;
   logic                     t_ge;
   logic [CIW:0]             sub_c;
   logic [TIW:0]             sub_t;
   logic [WORD_W-1:0]        qt_plus;
   logic [1:0]               ctr_rd;
   logic [1:0]               ctr_next;
   logic [TW-1:0]            tgt_rd;
   logic                     hit;
   logic                     c_wr_en;
   logic [CIW-1:0]           c_wr_addr;
   logic [1:0]               c_wr_data;
   logic                     t_wr_en;
   logic [TIW-1:0]           t_wr_addr;
   logic [TW-1:0]            t_wr_data;
   logic                     rd_en;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign clearing  = (state_ff == ST_CLEAR);
   assign word      = pc_ff[PC_W-1:2];

   assign prod_c  = word * MUL_C;
   assign prod_t  = word * MUL_T;
   assign qn_c    = qc_ff * NC_W;
   assign qn_t    = qt_ff * NT_W;
   assign diff_c  = word - qn_c[WORD_W-1:0];
   assign diff_t  = word - qn_t[WORD_W-1:0];
   assign c_ge    = (rc_ff >= NC_W);
   assign t_ge    = (rt_ff >= NT_W);
   assign sub_c   = rc_ff - NC_W;
   assign sub_t   = rt_ff - NT_W;
   assign qt_plus = qt_ff + WORD_W'(t_ge);

   assign hit = tgt_rd[TW-1] && (tgt_rd[TW-2:PC_W] == tag_ff);

   always_comb begin
      ctr_next = ctr_rd;
      if (taken_ff) begin
         if (ctr_rd != CTR_MAX) begin
            ctr_next = ctr_rd + 2'd1;
         end
      end else begin
         if (ctr_rd != CTR_MIN) begin
            ctr_next = ctr_rd - 2'd1;
         end
      end
   end

   assign rsp_load = (state_ff == ST_DATA) && (act_ff == ACT_PREDICT) &&
                     !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CLRW'(1);
            if (clr_cnt_ff == CLRW'(MAXN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_REM;
         ST_REM:  state_in = ST_FIX;
         ST_FIX:  state_in = ST_READ;
         ST_READ: state_in = ST_DATA;
         ST_DATA: begin
            if (act_ff == ACT_UPDATE || rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign act_in    = accept ? req_action : act_ff;
   assign pc_in     = accept ? req_pc : pc_ff;
   assign taken_in  = accept ? req_outcome_taken : taken_ff;
   assign target_in = accept ? req_outcome_target : target_ff;

   assign qc_in   = (state_ff == ST_MUL) ? prod_c[WORD_W+31:32] : qc_ff;
   assign qt_in   = (state_ff == ST_MUL) ? prod_t[WORD_W+31:32] : qt_ff;
   assign rc_in   = (state_ff == ST_REM) ? diff_c[CIW:0] : rc_ff;
   assign rt_in   = (state_ff == ST_REM) ? diff_t[TIW:0] : rt_ff;
   assign cidx_in = (state_ff != ST_FIX) ? cidx_ff :
                    (c_ge ? sub_c[CIW-1:0] : rc_ff[CIW-1:0]);
   assign tidx_in = (state_ff != ST_FIX) ? tidx_ff :
                    (t_ge ? sub_t[TIW-1:0] : rt_ff[TIW-1:0]);
   assign tag_in  = (state_ff == ST_FIX) ? qt_plus[TAGW-1:0] : tag_ff;

   assign rsp_valid_in  = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_taken_in  = rsp_load ? (ctr_rd >= CTR_TAKEN_MIN) : rsp_taken_ff;
   assign rsp_target_in = !rsp_load ? rsp_target_ff :
                          (hit ? tgt_rd[PC_W-1:0] : pc_ff + PC_STEP);

   assign rd_en = (state_ff == ST_READ);

   always_comb begin
      c_wr_en   = 1'b0;
      c_wr_addr = cidx_ff;
      c_wr_data = ctr_next;
      t_wr_en   = 1'b0;
      t_wr_addr = tidx_ff;
      t_wr_data = {1'b1, tag_ff, target_ff};
      if (clearing) begin
         c_wr_en   = (32'(clr_cnt_ff) < 32'(COUNTER_ENTRIES));
         c_wr_addr = clr_cnt_ff[CIW-1:0];
         c_wr_data = CTR_RESET;
         t_wr_en   = (32'(clr_cnt_ff) < 32'(TARGET_ENTRIES));
         t_wr_addr = clr_cnt_ff[TIW-1:0];
         t_wr_data = '0;
      end else if (state_ff == ST_DATA && act_ff == ACT_UPDATE) begin
         c_wr_en = 1'b1;
         t_wr_en = taken_ff;
      end
   end

   bbpbtb_ram #(
      .WIDTH(2),
      .DEPTH(COUNTER_ENTRIES)
   ) u_counter_ram (
      .clock  (clock),
      .wr_en  (c_wr_en),
      .wr_addr(c_wr_addr),
      .wr_data(c_wr_data),
      .rd_en  (rd_en),
      .rd_addr(cidx_ff),
      .rd_data(ctr_rd)
   );

   bbpbtb_ram #(
      .WIDTH(TW),
      .DEPTH(TARGET_ENTRIES)
   ) u_target_ram (
      .clock  (clock),
      .wr_en  (t_wr_en),
      .wr_addr(t_wr_addr),
      .wr_data(t_wr_data),
      .rd_en  (rd_en),
      .rd_addr(tidx_ff),
      .rd_data(tgt_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pc_ff         <= pc_in;
      taken_ff      <= taken_in;
      target_ff     <= target_in;
      qc_ff         <= qc_in;
      qt_ff         <= qt_in;
      rc_ff         <= rc_in;
      rt_ff         <= rt_in;
      cidx_ff       <= cidx_in;
      tidx_ff       <= tidx_in;
      tag_ff        <= tag_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_target_ff <= rsp_target_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_branch_taken  = rsp_taken_ff;
   assign rsp_branch_target = rsp_target_ff;

`ifndef ASSERT_OFF
   a_rsp_from_predict: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DATA && act_ff == ACT_PREDICT))
      else $error("response raised without a predict transaction");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted transaction did not start index computation");

   a_cidx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> 32'(cidx_ff) < 32'(COUNTER_ENTRIES))
      else $error("counter index out of range");

   a_tidx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> 32'(tidx_ff) < 32'(TARGET_ENTRIES))
      else $error("target index out of range");

   a_target_write: assert property (@(posedge clock) disable iff (reset)
      (t_wr_en && !clearing) |-> (act_ff == ACT_UPDATE && taken_ff &&
                                  state_ff == ST_DATA))
      else $error("target buffer written outside a taken update");
`endif

endmodule
